### src/bblc_pkg.sv
// Package for the button brightness LED control block.
// Holds the word types, action codes, register indexes and the PWM duty table.
// No dependencies.
package bblc_pkg;

    localparam int LEVEL_W   = 5;
    localparam int DUTY_W    = 15;
    localparam int LED_W     = 8;
    localparam int ACTION_W  = 2;
    localparam int CFG_IDX_W = 2;
    localparam int HOLD_W    = 6;
    localparam int SAVE_W    = 8;

    localparam logic [ACTION_W-1:0] ACT_ADJUST = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_BLINK  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SAVE   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MIN     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MAX     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_DEFAULT = 2'd2;

    localparam logic [LEVEL_W-1:0] LEVEL_MIN_RST     = 5'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX_RST     = 5'd30;
    localparam logic [LEVEL_W-1:0] LEVEL_DEFAULT_RST = 5'd15;
    localparam logic [LEVEL_W-1:0] LEVEL_COUNT       = 5'd31;
    localparam logic [LEVEL_W-1:0] ANGLE_BACKOFF     = 5'd3;

    // Compare values already scaled by three fifths, rounded down.
    localparam logic [DUTY_W-1:0] DUTY_ROM [0:30] = '{
        15'd29998, 15'd29952, 15'd29895, 15'd29830, 15'd29753, 15'd29664,
        15'd29559, 15'd29437, 15'd29295, 15'd29128, 15'd28934, 15'd28707,
        15'd28441, 15'd28131, 15'd27769, 15'd27346, 15'd26851, 15'd26274,
        15'd25600, 15'd24811, 15'd23891, 15'd22815, 15'd21559, 15'd20091,
        15'd18377, 15'd16374, 15'd14034, 15'd11301, 15'd8108,  15'd4378,
        15'd21
    };

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                switch_pressed;
        logic                angle_error;
        logic [LED_W-1:0]    led_commands;
        logic                save_failed;
    } item_t;

    typedef struct packed {
        logic               duty_valid;
        logic [DUTY_W-1:0]  duty_value;
        logic               leds_valid;
        logic [LED_W-1:0]   led_mask;
        logic               save_request;
        logic [LEVEL_W-1:0] level;
    } result_t;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] index;
        logic [LEVEL_W-1:0]   wdata;
    } cfg_wr_t;

    function automatic logic [DUTY_W-1:0] duty_lookup(input logic [LEVEL_W-1:0] lvl);
        logic [DUTY_W-1:0] val;
        val = '0;
        if (lvl < LEVEL_COUNT) begin
            val = DUTY_ROM[lvl];
        end
        return val;
    endfunction

endpackage

### src/bblc_in_reg.sv
// Input register of the button brightness LED control block.
// Captures one input word and holds it until the control stage takes it.
// Depends on bblc_pkg.
module bblc_in_reg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  bblc_pkg::item_t s_item,
    input  logic           take,
    output logic           item_valid,
    output bblc_pkg::item_t item
);
    import bblc_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

### src/bblc_ctrl.sv
// Control stage of the button brightness LED control block.
// Holds the level registers and the brightness state, and forms one result per word.
// Depends on bblc_pkg.
module bblc_ctrl #(
    parameter int LED_COUNT  = 8,
    parameter int HOLD_TICKS = 50,
    parameter int SAVE_TICKS = 250
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  bblc_pkg::cfg_wr_t cfg,
    input  logic              fire,
    input  bblc_pkg::item_t   item,
    output bblc_pkg::result_t result
);
    import bblc_pkg::*;

    localparam logic [HOLD_W-1:0] HOLD_LOAD = HOLD_W'(HOLD_TICKS);
    localparam logic [SAVE_W-1:0] SAVE_LOAD = SAVE_W'(SAVE_TICKS);

    logic [LEVEL_W-1:0] level_min_reg, level_max_reg, level_default_reg;
    logic [LEVEL_W-1:0] bright_reg, bright_next;
    logic               ramp_up_reg, ramp_up_next;
    logic               button_last_reg, button_last_next;
    logic [HOLD_W-1:0]  hold_reg, hold_next;
    logic [SAVE_W-1:0]  save_reg, save_next;
    logic [SAVE_W-1:0]  save_work;
    logic               phase_reg, phase_next;
    logic [LEVEL_W-1:0] blink_level;
    logic               blink_level_ok;
    logic               led_off;

    assign blink_level_ok = !item.angle_error || (level_max_reg >= ANGLE_BACKOFF);
    assign blink_level    = item.angle_error ? (level_max_reg - ANGLE_BACKOFF) : bright_reg;
    assign led_off        = item.angle_error && !phase_reg;

    always_comb begin
        bright_next      = bright_reg;
        ramp_up_next     = ramp_up_reg;
        button_last_next = button_last_reg;
        hold_next        = hold_reg;
        save_next        = save_reg;
        save_work        = save_reg;
        phase_next       = phase_reg;
        result           = '0;

        unique case (item.action)
            ACT_ADJUST: begin
                if (!item.switch_pressed && button_last_reg) begin
                    ramp_up_next = !ramp_up_reg;
                end
                button_last_next = item.switch_pressed;
                if (item.switch_pressed) begin
                    if (hold_reg == '0) begin
                        bright_next  = level_min_reg;
                        ramp_up_next = 1'b0;
                    end else begin
                        hold_next = hold_reg - 1'b1;
                        if (ramp_up_reg) begin
                            if (bright_reg < level_max_reg) begin
                                bright_next = bright_reg + 1'b1;
                            end
                        end else if (bright_reg > level_min_reg) begin
                            bright_next = bright_reg - 1'b1;
                        end
                        result.duty_valid = (bright_next < LEVEL_COUNT);
                        result.duty_value = duty_lookup(bright_next);
                    end
                    save_work = SAVE_LOAD;
                end else begin
                    hold_next = HOLD_LOAD;
                end
                save_next = save_work;
                if (save_work != '0) begin
                    save_next           = save_work - 1'b1;
                    result.save_request = (save_work == SAVE_W'(1));
                end
            end
            ACT_BLINK: begin
                if (blink_level_ok && (blink_level < LEVEL_COUNT)) begin
                    result.duty_valid = 1'b1;
                    result.duty_value = duty_lookup(blink_level);
                end
                phase_next        = !phase_reg;
                result.leds_valid = 1'b1;
                for (int i = 0; i < LED_W; i++) begin
                    result.led_mask[i] = (i < LED_COUNT) && item.led_commands[i] && !led_off;
                end
            end
            ACT_SAVE: begin
                if (item.save_failed) begin
                    bright_next = level_default_reg;
                end
            end
            default: begin
            end
        endcase

        result.level = bright_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_min_reg     <= LEVEL_MIN_RST;
            level_max_reg     <= LEVEL_MAX_RST;
            level_default_reg <= LEVEL_DEFAULT_RST;
        end else if (cfg.we) begin
            unique case (cfg.index)
                REG_LEVEL_MIN:     level_min_reg     <= cfg.wdata;
                REG_LEVEL_MAX:     level_max_reg     <= cfg.wdata;
                REG_LEVEL_DEFAULT: level_default_reg <= cfg.wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bright_reg      <= LEVEL_DEFAULT_RST;
            ramp_up_reg     <= 1'b0;
            button_last_reg <= 1'b0;
            hold_reg        <= HOLD_LOAD;
            save_reg        <= '0;
            phase_reg       <= 1'b0;
        end else if (fire) begin
            bright_reg      <= bright_next;
            ramp_up_reg     <= ramp_up_next;
            button_last_reg <= button_last_next;
            hold_reg        <= hold_next;
            save_reg        <= save_next;
            phase_reg       <= phase_next;
        end
    end

endmodule

### src/bblc_out_reg.sv
// Result register of the button brightness LED control block.
// Holds one result word until the receiver takes it.
// Depends on bblc_pkg.
module bblc_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  bblc_pkg::result_t result,
    output logic              space,
    output logic              m_valid,
    input  logic              m_ready,
    output bblc_pkg::result_t m_result
);
    import bblc_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    assign space    = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_result = result_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (space) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= result;
        end
    end

endmodule

### src/button_brightness_led_control_core.sv
// Top level of the button brightness LED control block.
// Instantiates the input register, the control stage and the result register.
// Depends on bblc_pkg, bblc_in_reg, bblc_ctrl and bblc_out_reg.
//
// Each input word is one timed event: an adjust tick, a blink tick or a save
// report, chosen by s_action. Every accepted word gives exactly one result word
// on the m_ channel, carrying the PWM compare value, the LED mask, the save
// request pulse and the brightness level after the event.
// A word is taken into the input register, evaluated by the control stage and
// written into the result register. One word is accepted every cycle while
// the receiver keeps m_ready high.
// When the receiver holds m_ready low, the result register keeps its word and
// the input register holds one more word, after which s_ready falls.
// The user must write the level registers via cfg_we, cfg_index and cfg_wdata
// only while the block is idle, which it does not enforce. Reset sets them to
// 0, 30 and 15, the brightness to 15, ramping down, and empties both registers.
module button_brightness_led_control_core #(
    parameter int LED_COUNT  = 8,
    parameter int HOLD_TICKS = 50,
    parameter int SAVE_TICKS = 250
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [bblc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bblc_pkg::LEVEL_W-1:0]       cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [bblc_pkg::ACTION_W-1:0]      s_action,
    input  logic                               s_switch_pressed,
    input  logic                               s_angle_error,
    input  logic [bblc_pkg::LED_W-1:0]         s_led_commands,
    input  logic                               s_save_failed,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_duty_valid,
    output logic [bblc_pkg::DUTY_W-1:0]        m_duty_value,
    output logic                               m_leds_valid,
    output logic [bblc_pkg::LED_W-1:0]         m_led_mask,
    output logic                               m_save_request,
    output logic [bblc_pkg::LEVEL_W-1:0]       m_level
);
    import bblc_pkg::*;

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    space;
    logic    fire;
    cfg_wr_t cfg;
    result_t result;
    result_t m_result;

    assign s_item = '{action:         s_action,
                      switch_pressed: s_switch_pressed,
                      angle_error:    s_angle_error,
                      led_commands:   s_led_commands,
                      save_failed:    s_save_failed};

    assign cfg  = '{we: cfg_we, index: cfg_index, wdata: cfg_wdata};
    assign fire = item_valid && space;

    bblc_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    bblc_ctrl #(
        .LED_COUNT  (LED_COUNT),
        .HOLD_TICKS (HOLD_TICKS),
        .SAVE_TICKS (SAVE_TICKS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .fire    (fire),
        .item    (item),
        .result  (result)
    );

    bblc_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire),
        .result   (result),
        .space    (space),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

    assign m_duty_valid   = m_result.duty_valid;
    assign m_duty_value   = m_result.duty_value;
    assign m_leds_valid   = m_result.leds_valid;
    assign m_led_mask     = m_result.led_mask;
    assign m_save_request = m_result.save_request;
    assign m_level        = m_result.level;

endmodule

### src/bblc_checker.sv
// Port checker for the button brightness LED control block.
// Watches the top level's ports and is bound to the top level below.
// Depends on bblc_pkg.
module bblc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_duty_valid,
    input logic [bblc_pkg::DUTY_W-1:0]   m_duty_value,
    input logic                          m_leds_valid,
    input logic [bblc_pkg::LED_W-1:0]    m_led_mask,
    input logic                          m_save_request
);
    import bblc_pkg::*;

    // A result word that is not taken stays offered.
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    // Without a duty word the compare value reads as zero.
    a_duty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_duty_valid |-> m_duty_value == '0)
        else $error("duty value set without duty valid");

    // The LED mask is driven only on blink ticks.
    a_mask_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_leds_valid |-> m_led_mask == '0)
        else $error("LED mask set without LEDs valid");

    // A save request comes only from an adjust tick, never with the LED mask.
    a_save_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_leds_valid |-> !m_save_request)
        else $error("save request on a blink tick");

    // Both registers are empty after reset, so a word is accepted at once.
    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_ready)
        else $error("input not ready after reset");

endmodule

bind button_brightness_led_control_core bblc_checker u_bblc_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_duty_valid   (m_duty_valid),
    .m_duty_value   (m_duty_value),
    .m_leds_valid   (m_leds_valid),
    .m_led_mask     (m_led_mask),
    .m_save_request (m_save_request)
);
